[design/amx_pkg.sv]
// Shared types, constants and tables for the 3x3 affine matrix accumulator.
package amx_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANG_FRAC         = 29;
  localparam int ATAN_ENTRIES     = 24;

  localparam logic [31:0] ANG_TWO_PI  = 32'd3373259426;
  localparam logic signed [33:0] ANG_PI      = 34'sd1686629713;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd843314856;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd326016437;

  typedef enum logic [2:0] {
    CMD_IDENT  = 3'd0,
    CMD_MUL    = 3'd1,
    CMD_SCALE  = 3'd2,
    CMD_ROW    = 3'd3,
    CMD_ROTATE = 3'd4,
    CMD_XLATE  = 3'd5,
    CMD_ORIENT = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RED, ST_RFIX, ST_CORD, ST_CFIN, ST_MLOAD, ST_MBIT, ST_MACC, ST_DONE
  } state_t;

  function automatic logic signed [33:0] atan_q29(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd421657428;
      5'd1:  v = 32'd248918915;
      5'd2:  v = 32'd131521918;
      5'd3:  v = 32'd66762349;
      5'd4:  v = 32'd33510843;
      5'd5:  v = 32'd16771758;
      5'd6:  v = 32'd8387925;
      5'd7:  v = 32'd4194219;
      5'd8:  v = 32'd2097141;
      5'd9:  v = 32'd1048575;
      5'd10: v = 32'd524288;
      5'd11: v = 32'd262144;
      5'd12: v = 32'd131072;
      5'd13: v = 32'd65536;
      5'd14: v = 32'd32768;
      5'd15: v = 32'd16384;
      5'd16: v = 32'd8192;
      5'd17: v = 32'd4096;
      5'd18: v = 32'd2048;
      5'd19: v = 32'd1024;
      5'd20: v = 32'd512;
      5'd21: v = 32'd256;
      5'd22: v = 32'd128;
      5'd23: v = 32'd64;
      default: v = 32'd0;
    endcase
    return $signed({2'b00, v});
  endfunction

  // orientation entry: 2'b01 = +1, 2'b11 = -1, 2'b00 = 0
  function automatic logic [1:0] orient_val(input logic [2:0] code, input logic [3:0] idx);
    logic [17:0] row;
    unique case (code)
      3'd0: row = {2'b01, 2'b00, 2'b00, 2'b00, 2'b01, 2'b00, 2'b00, 2'b00, 2'b01};
      3'd1: row = {2'b00, 2'b11, 2'b00, 2'b01, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01};
      3'd2: row = {2'b11, 2'b00, 2'b00, 2'b00, 2'b11, 2'b00, 2'b00, 2'b00, 2'b01};
      3'd3: row = {2'b00, 2'b01, 2'b00, 2'b11, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01};
      3'd4: row = {2'b11, 2'b00, 2'b00, 2'b00, 2'b01, 2'b00, 2'b00, 2'b00, 2'b01};
      3'd5: row = {2'b00, 2'b11, 2'b00, 2'b11, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01};
      3'd6: row = {2'b01, 2'b00, 2'b00, 2'b00, 2'b11, 2'b00, 2'b00, 2'b00, 2'b01};
      3'd7: row = {2'b00, 2'b01, 2'b00, 2'b01, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01};
      default: row = '0;
    endcase
    return row[(8 - idx) * 2 +: 2];
  endfunction

endpackage

[design/affine_matrix_accumulator_3x3.sv]
// Top level: 3x3 Q-format affine matrix accumulator with a bit-serial multiplier.
//
// One command per input transaction (in_valid/in_ready); every transaction
// returns the updated 3x3 matrix on the result channel (out_valid/out_ready).
// The matrix is held internally and is set to identity at reset (rst_n low,
// synchronous).
// Products run through one shift-add multiplier that retires one multiplier
// bit per cycle: each product loads its operands, shifts through all 32
// multiplier bits and then accumulates. A full matrix product is 27 products;
// a row scale is 3 products. Rotation adds FRAC-dependent angle reduction
// and CORDIC iterations ahead of the product. Identity, command 7 and an
// out-of-range row skip the multiplier and go straight to the result.
// The result sits in its own output register, so a new command is taken as
// soon as the engine is idle even while the previous result waits. If the
// receiver stalls and a second result is ready, the engine holds it until
// the output register frees up.
module affine_matrix_accumulator_3x3 #(
  parameter int FRAC_BITS    = amx_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = amx_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_opnd_00,
  input  logic signed [31:0] in_opnd_01,
  input  logic signed [31:0] in_opnd_02,
  input  logic signed [31:0] in_opnd_10,
  input  logic signed [31:0] in_opnd_11,
  input  logic signed [31:0] in_opnd_12,
  input  logic signed [31:0] in_opnd_20,
  input  logic signed [31:0] in_opnd_21,
  input  logic signed [31:0] in_opnd_22,
  input  logic signed [31:0] in_amount,
  input  logic [2:0]         in_select,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_00,
  output logic signed [31:0] out_res_01,
  output logic signed [31:0] out_res_02,
  output logic signed [31:0] out_res_10,
  output logic signed [31:0] out_res_11,
  output logic signed [31:0] out_res_12,
  output logic signed [31:0] out_res_20,
  output logic signed [31:0] out_res_21,
  output logic signed [31:0] out_res_22
);

  localparam int SH  = amx_pkg::ANG_FRAC - FRAC_BITS;
  localparam int MW  = 32 + SH;
  localparam int NST = (CORDIC_STEPS < amx_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
                                                                : amx_pkg::ATAN_ENTRIES;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF64 = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [33:0] HALF_ANG = 34'sd1 <<< (SH - 1);
  localparam logic signed [63:0] SMAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SMIN = -64'sh0000_0000_8000_0000;

  amx_pkg::state_t state_r, state_nxt;

  logic signed [31:0] mat_r [9];
  logic signed [31:0] res_r [9];
  logic signed [31:0] bm_r  [9];
  logic signed [31:0] bm_init [9];
  logic signed [31:0] out_r [9];
  logic               out_valid_r;

  amx_pkg::cmd_t      cmd_r;
  logic [1:0]         row_r, col_r, k_r;
  logic [4:0]         cnt_r;
  logic signed [31:0] amt_r;

  logic [MW-1:0]      mag_r;
  logic               aneg_r, fneg_r;
  logic signed [33:0] x_r, y_r, z_r;

  logic signed [63:0] a_sh_r, acc_r, sum_r;
  logic [31:0]        b_sh_r;

  logic [3:0]         a_idx, b_idx;
  logic signed [63:0] rnd, tsum, addend;
  logic [MW-1:0]      thr;
  logic signed [33:0] r0, r1, xs, ys, cv, sv;
  logic               row_mode, last_term, last_ent, out_free;

  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return 4'({r, 1'b0}) + 4'(r) + 4'(c);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > SMAX) return 32'sh7FFF_FFFF;
    if (v < SMIN) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  assign in_ready  = (state_r == amx_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign row_mode  = (cmd_r == amx_pkg::CMD_ROW);
  assign last_term = row_mode || (k_r == 2'd2);
  assign last_ent  = (col_r == 2'd2) && (row_mode || row_r == 2'd2);

  always_comb begin
    a_idx  = idx3(row_r, row_mode ? col_r : k_r);
    b_idx  = idx3(k_r, col_r);
    rnd    = (acc_r + HALF64) >>> FRAC_BITS;
    tsum   = sum_r + rnd;
    addend = (cnt_r == 5'd31) ? -a_sh_r : a_sh_r;
    thr    = {{(MW - 32){1'b0}}, amx_pkg::ANG_TWO_PI} << cnt_r;
    r0     = aneg_r ? -$signed({2'b00, mag_r[31:0]}) : $signed({2'b00, mag_r[31:0]});
    if (r0 > amx_pkg::ANG_PI) r1 = r0 - $signed({2'b00, amx_pkg::ANG_TWO_PI});
    else if (r0 < -amx_pkg::ANG_PI) r1 = r0 + $signed({2'b00, amx_pkg::ANG_TWO_PI});
    else r1 = r0;
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    cv = (x_r + HALF_ANG) >>> SH;
    sv = (y_r + HALF_ANG) >>> SH;
  end

  // operand matrix for the incoming command; identity where the command leaves a gap
  always_comb begin
    for (int i = 0; i < 9; i++) bm_init[i] = (i % 4 == 0) ? ONE : 32'sd0;
    unique case (amx_pkg::cmd_t'(in_command))
      amx_pkg::CMD_MUL: begin
        bm_init[0] = in_opnd_00; bm_init[1] = in_opnd_01; bm_init[2] = in_opnd_02;
        bm_init[3] = in_opnd_10; bm_init[4] = in_opnd_11; bm_init[5] = in_opnd_12;
        bm_init[6] = in_opnd_20; bm_init[7] = in_opnd_21; bm_init[8] = in_opnd_22;
      end
      amx_pkg::CMD_SCALE: begin
        bm_init[0] = in_opnd_00;
        bm_init[4] = in_opnd_11;
      end
      amx_pkg::CMD_XLATE: begin
        bm_init[2] = in_opnd_02;
        bm_init[5] = in_opnd_12;
      end
      amx_pkg::CMD_ORIENT:
        for (int i = 0; i < 9; i++) begin
          unique case (amx_pkg::orient_val(in_select, 4'(i)))
            2'b01:   bm_init[i] = ONE;
            2'b11:   bm_init[i] = -ONE;
            default: bm_init[i] = 32'sd0;
          endcase
        end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      amx_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (amx_pkg::cmd_t'(in_command))
            amx_pkg::CMD_IDENT, amx_pkg::CMD_NONE: state_nxt = amx_pkg::ST_DONE;
            amx_pkg::CMD_ROW:
              state_nxt = (in_select > 3'd2) ? amx_pkg::ST_DONE : amx_pkg::ST_MLOAD;
            amx_pkg::CMD_ROTATE: state_nxt = amx_pkg::ST_RED;
            default: state_nxt = amx_pkg::ST_MLOAD;
          endcase
        end
      end
      amx_pkg::ST_RED:   if (cnt_r == 5'd0) state_nxt = amx_pkg::ST_RFIX;
      amx_pkg::ST_RFIX:  state_nxt = amx_pkg::ST_CORD;
      amx_pkg::ST_CORD:  if (cnt_r == 5'(NST - 1)) state_nxt = amx_pkg::ST_CFIN;
      amx_pkg::ST_CFIN:  state_nxt = amx_pkg::ST_MLOAD;
      amx_pkg::ST_MLOAD: state_nxt = amx_pkg::ST_MBIT;
      amx_pkg::ST_MBIT:  if (cnt_r == 5'd31) state_nxt = amx_pkg::ST_MACC;
      amx_pkg::ST_MACC:
        state_nxt = (last_term && last_ent) ? amx_pkg::ST_DONE : amx_pkg::ST_MLOAD;
      amx_pkg::ST_DONE:  if (out_free) state_nxt = amx_pkg::ST_IDLE;
      default: state_nxt = amx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= amx_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) mat_r[i] <= (i % 4 == 0) ? ONE : 32'sd0;
    end else begin
      unique case (state_r)
        amx_pkg::ST_IDLE: begin
          if (in_valid) begin
            cmd_r <= amx_pkg::cmd_t'(in_command);
            amt_r <= in_amount;
            row_r <= (amx_pkg::cmd_t'(in_command) == amx_pkg::CMD_ROW) ? in_select[1:0] : 2'd0;
            col_r <= 2'd0;
            k_r   <= 2'd0;
            for (int i = 0; i < 9; i++) begin
              res_r[i] <= mat_r[i];
              bm_r[i]  <= bm_init[i];
            end
            unique case (amx_pkg::cmd_t'(in_command))
              amx_pkg::CMD_IDENT:
                for (int i = 0; i < 9; i++) mat_r[i] <= (i % 4 == 0) ? ONE : 32'sd0;
              amx_pkg::CMD_ROTATE: begin
                aneg_r <= in_amount[31];
                mag_r  <= in_amount[31] ? MW'(-{{(MW - 32){1'b1}}, in_amount}) << SH
                                        : MW'({{(MW - 32){1'b0}}, in_amount}) << SH;
                cnt_r  <= 5'(SH);
              end
              default: ;
            endcase
          end
        end
        amx_pkg::ST_RED: begin
          if (mag_r >= thr) mag_r <= mag_r - thr;
          cnt_r <= cnt_r - 5'd1;
        end
        amx_pkg::ST_RFIX: begin
          if (r1 > amx_pkg::ANG_HALF_PI) begin
            z_r <= r1 - amx_pkg::ANG_PI;
            fneg_r <= 1'b1;
          end else if (r1 < -amx_pkg::ANG_HALF_PI) begin
            z_r <= r1 + amx_pkg::ANG_PI;
            fneg_r <= 1'b1;
          end else begin
            z_r <= r1;
            fneg_r <= 1'b0;
          end
          x_r   <= amx_pkg::CORDIC_GAIN;
          y_r   <= 34'sd0;
          cnt_r <= 5'd0;
        end
        amx_pkg::ST_CORD: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - amx_pkg::atan_q29(cnt_r);
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + amx_pkg::atan_q29(cnt_r);
          end
          cnt_r <= cnt_r + 5'd1;
        end
        amx_pkg::ST_CFIN: begin
          bm_r[0] <= fneg_r ? -cv[31:0] : cv[31:0];
          bm_r[4] <= fneg_r ? -cv[31:0] : cv[31:0];
          bm_r[3] <= fneg_r ? -sv[31:0] : sv[31:0];
          bm_r[1] <= fneg_r ? sv[31:0] : -sv[31:0];
        end
        amx_pkg::ST_MLOAD: begin
          a_sh_r <= 64'(mat_r[a_idx]);
          b_sh_r <= row_mode ? amt_r : bm_r[b_idx];
          acc_r  <= 64'sd0;
          cnt_r  <= 5'd0;
          if (k_r == 2'd0) sum_r <= 64'sd0;
        end
        amx_pkg::ST_MBIT: begin
          if (b_sh_r[0]) acc_r <= acc_r + addend;
          a_sh_r <= a_sh_r <<< 1;
          b_sh_r <= b_sh_r >> 1;
          cnt_r  <= cnt_r + 5'd1;
        end
        amx_pkg::ST_MACC: begin
          if (last_term) begin
            res_r[idx3(row_r, col_r)] <= sat32(tsum);
            k_r <= 2'd0;
            if (col_r == 2'd2) begin
              col_r <= 2'd0;
              row_r <= row_r + 2'd1;
            end else begin
              col_r <= col_r + 2'd1;
            end
            if (last_ent && !row_mode)
              for (int i = 0; i < 9; i++)
                mat_r[i] <= (4'(i) == idx3(row_r, col_r)) ? sat32(tsum) : res_r[i];
            if (last_ent && row_mode) begin
              mat_r[idx3(row_r, 2'd0)] <= res_r[idx3(row_r, 2'd0)];
              mat_r[idx3(row_r, 2'd1)] <= res_r[idx3(row_r, 2'd1)];
              mat_r[idx3(row_r, 2'd2)] <= sat32(tsum);
            end
          end else begin
            sum_r <= tsum;
            k_r   <= k_r + 2'd1;
          end
        end
        amx_pkg::ST_DONE: ;
        default: ;
      endcase

      if (state_r == amx_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < 9; i++) out_r[i] <= mat_r[i];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_res_00 = out_r[0];
  assign out_res_01 = out_r[1];
  assign out_res_02 = out_r[2];
  assign out_res_10 = out_r[3];
  assign out_res_11 = out_r[4];
  assign out_res_12 = out_r[5];
  assign out_res_20 = out_r[6];
  assign out_res_21 = out_r[7];
  assign out_res_22 = out_r[8];

  // a held result must not be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_00) && $stable(out_res_22))
    else $error("result overwritten while stalled");

  // the multiplier works through all 32 multiplier bits before accumulating
  a_mbit_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == amx_pkg::ST_MACC |-> $past(state_r) == amx_pkg::ST_MBIT && $past(cnt_r) == 5'd31)
    else $error("multiplier bit count wrong");

  // new work starts only from idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == amx_pkg::ST_IDLE && !in_valid |=> state_r == amx_pkg::ST_IDLE)
    else $error("engine left idle without a transaction");

  // angle after reduction lies within one full turn
  a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == amx_pkg::ST_RFIX |-> mag_r < MW'(amx_pkg::ANG_TWO_PI))
    else $error("angle reduction incomplete");

endmodule

[sim/affine_matrix_accumulator_3x3_tb.sv]
// Self-checking testbench for the 3x3 affine matrix accumulator.
`timescale 1ns / 100ps

module affine_matrix_accumulator_3x3_tb;

  typedef logic [8:0][31:0] mat_t;

  typedef struct {
    amx_pkg::cmd_t cmd;
    mat_t        opnd;
    logic [31:0] amount;
    logic [2:0]  sel;
    bit          known;
    mat_t        want;
  } cmd_item_t;

  localparam int  NUM_RANDOM = 1100;
  localparam int  STALL_LIMIT = 20000;
  localparam int  FRAC = 16;
  localparam longint ONE = 64'sd65536;
  localparam longint PI_Q29 = 64'sd1686629713;
  localparam longint HALF_PI_Q29 = 64'sd843314856;
  localparam longint TWO_PI_Q29 = 64'sd3373259426;
  localparam longint GAIN_Q29 = 64'sd326016437;

  localparam longint ATAN_TAB [24] = '{
    421657428, 248918915, 131521918, 66762349, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096,
    2048, 1024, 512, 256, 128, 64};

  // orientation codes: normal, 90, 180, 270 and flipped forms
  localparam int ORIENT_TAB [8][9] = '{
    '{ 1, 0, 0,  0, 1, 0,  0, 0, 1},
    '{ 0,-1, 0,  1, 0, 0,  0, 0, 1},
    '{-1, 0, 0,  0,-1, 0,  0, 0, 1},
    '{ 0, 1, 0, -1, 0, 0,  0, 0, 1},
    '{-1, 0, 0,  0, 1, 0,  0, 0, 1},
    '{ 0,-1, 0, -1, 0, 0,  0, 0, 1},
    '{ 1, 0, 0,  0,-1, 0,  0, 0, 1},
    '{ 0, 1, 0,  1, 0, 0,  0, 0, 1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = '0;
  logic signed [31:0] in_opnd_00 = '0, in_opnd_01 = '0, in_opnd_02 = '0;
  logic signed [31:0] in_opnd_10 = '0, in_opnd_11 = '0, in_opnd_12 = '0;
  logic signed [31:0] in_opnd_20 = '0, in_opnd_21 = '0, in_opnd_22 = '0;
  logic signed [31:0] in_amount = '0;
  logic [2:0] in_select = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_res_00, out_res_01, out_res_02;
  logic signed [31:0] out_res_10, out_res_11, out_res_12;
  logic signed [31:0] out_res_20, out_res_21, out_res_22;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  affine_matrix_accumulator_3x3 u_top (.*);

  mat_t      xform;          // predicted matrix state
  mat_t      pending_mats[$];
  cmd_item_t directed[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        idle_cnt = 0;
  bit        quiet = 1'b0;
  int        cmd_hits[8];

  function automatic mat_t identity_mat();
    mat_t m;
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 32'(ONE) : 32'd0;
    return m;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint round_mul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  function automatic void right_mul(longint b[9]);
    mat_t r;
    for (int row = 0; row < 3; row++)
      for (int col = 0; col < 3; col++)
        r[row * 3 + col] = sat32(
          round_mul(longint'($signed(xform[row * 3])), b[col]) +
          round_mul(longint'($signed(xform[row * 3 + 1])), b[3 + col]) +
          round_mul(longint'($signed(xform[row * 3 + 2])), b[6 + col]));
    xform = r;
  endfunction

  function automatic void unit_op(output longint b[9]);
    for (int i = 0; i < 9; i++) b[i] = (i % 4 == 0) ? ONE : 64'sd0;
  endfunction

  function automatic void cordic_cos_sin(longint ang, output longint c, output longint s);
    longint r, x, y, nx;
    bit neg;
    r = (ang * (64'sd1 <<< 13)) % TWO_PI_Q29;
    neg = 1'b0;
    x = GAIN_Q29;
    y = 0;
    if (r > PI_Q29) r -= TWO_PI_Q29;
    if (r < -PI_Q29) r += TWO_PI_Q29;
    if (r > HALF_PI_Q29) begin
      r -= PI_Q29;
      neg = 1'b1;
    end else if (r < -HALF_PI_Q29) begin
      r += PI_Q29;
      neg = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r += ATAN_TAB[i];
      end
      x = nx;
    end
    c = (x + (64'sd1 <<< 12)) >>> 13;
    s = (y + (64'sd1 <<< 12)) >>> 13;
    if (neg) begin
      c = -c;
      s = -s;
    end
  endfunction

  // advance the predicted matrix by one command
  function automatic void apply_cmd(cmd_item_t it);
    longint b[9];
    longint c, s;
    case (it.cmd)
      amx_pkg::CMD_IDENT: xform = identity_mat();
      amx_pkg::CMD_MUL: begin
        for (int i = 0; i < 9; i++) b[i] = longint'($signed(it.opnd[i]));
        right_mul(b);
      end
      amx_pkg::CMD_SCALE: begin
        unit_op(b);
        b[0] = longint'($signed(it.opnd[0]));
        b[4] = longint'($signed(it.opnd[4]));
        right_mul(b);
      end
      amx_pkg::CMD_ROW: begin
        if (it.sel <= 3'd2)
          for (int i = 0; i < 3; i++)
            xform[it.sel * 3 + i] = sat32(round_mul(
              longint'($signed(xform[it.sel * 3 + i])), longint'($signed(it.amount))));
      end
      amx_pkg::CMD_ROTATE: begin
        cordic_cos_sin(longint'($signed(it.amount)), c, s);
        unit_op(b);
        b[0] = c;
        b[1] = -s;
        b[3] = s;
        b[4] = c;
        right_mul(b);
      end
      amx_pkg::CMD_XLATE: begin
        unit_op(b);
        b[2] = longint'($signed(it.opnd[2]));
        b[5] = longint'($signed(it.opnd[5]));
        right_mul(b);
      end
      amx_pkg::CMD_ORIENT: begin
        for (int i = 0; i < 9; i++) b[i] = longint'(ORIENT_TAB[it.sel][i]) * ONE;
        right_mul(b);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rand_q();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
  endfunction

  function automatic cmd_item_t make_item(amx_pkg::cmd_t cmd, logic [31:0] amt,
                                          logic [2:0] sel);
    cmd_item_t it;
    it.cmd = cmd;
    for (int i = 0; i < 9; i++) it.opnd[i] = $urandom;
    it.amount = amt;
    it.sel = sel;
    it.known = 1'b0;
    it.want = '0;
    return it;
  endfunction

  function automatic void add_known(amx_pkg::cmd_t cmd, logic [2:0] sel);
    cmd_item_t it;
    it = make_item(cmd, $urandom, sel);
    it.known = 1'b1;
    it.want = identity_mat();
    directed.push_back(it);
  endfunction

  function automatic void add_ops(amx_pkg::cmd_t cmd, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] amt, logic [2:0] sel);
    cmd_item_t it;
    it = make_item(cmd, amt, sel);
    case (cmd)
      amx_pkg::CMD_SCALE: begin
        it.opnd[0] = a;
        it.opnd[4] = b;
      end
      amx_pkg::CMD_XLATE: begin
        it.opnd[2] = a;
        it.opnd[5] = b;
      end
      amx_pkg::CMD_MUL: for (int i = 0; i < 9; i++) it.opnd[i] = a;
      default: ;
    endcase
    directed.push_back(it);
  endfunction

  task automatic send_cmd(cmd_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= it.cmd;
    {in_opnd_22, in_opnd_21, in_opnd_20, in_opnd_12, in_opnd_11, in_opnd_10,
     in_opnd_02, in_opnd_01, in_opnd_00} <= it.opnd;
    in_amount  <= it.amount;
    in_select  <= it.sel;
    do @(posedge clk); while (!in_ready);
    apply_cmd(it);
    pending_mats.push_back(it.known ? it.want : xform);
    cmd_hits[it.cmd]++;
    n_sent++;
  endtask

  // receiver backpressure
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_ready <= rst_n;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(1, 4) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mat_t got, exp_m;
    if (rst_n && out_valid && out_ready) begin
      got = {out_res_22, out_res_21, out_res_20, out_res_12, out_res_11, out_res_10,
             out_res_02, out_res_01, out_res_00};
      if (pending_mats.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        errors++;
      end else begin
        exp_m = pending_mats.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== exp_m[i]) begin
            $display("%0t: res_%0d%0d expected %0d (0x%08h) actual %0d (0x%08h)",
                     $time, i / 3, i % 3, $signed(exp_m[i]), exp_m[i],
                     $signed(got[i]), got[i]);
            errors++;
          end
        n_checked++;
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending_mats.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    cmd_item_t it;
    int k, wait_cnt;
    xform = identity_mat();

    add_known(amx_pkg::CMD_IDENT, 3'd0);
    add_known(amx_pkg::CMD_NONE, 3'd5);
    add_known(amx_pkg::CMD_ROW, 3'd3);
    add_known(amx_pkg::CMD_ROW, 3'd7);
    add_ops(amx_pkg::CMD_SCALE, 32'h0002_0000, 32'hffff_8000, 32'd0, 3'd0);
    add_ops(amx_pkg::CMD_ROW, 32'd0, 32'd0, 32'h7fffffff, 3'd0);
    add_ops(amx_pkg::CMD_ROW, 32'd0, 32'd0, 32'h80000000, 3'd1);
    add_ops(amx_pkg::CMD_ROW, 32'd0, 32'd0, 32'h0003_0000, 3'd2);
    add_ops(amx_pkg::CMD_XLATE, 32'h7fffffff, 32'h80000000, 32'd0, 3'd0);
    add_ops(amx_pkg::CMD_MUL, 32'h7fffffff, 32'd0, 32'd0, 3'd0);
    add_ops(amx_pkg::CMD_MUL, 32'h80000000, 32'd0, 32'd0, 3'd0);
    add_known(amx_pkg::CMD_IDENT, 3'd2);
    for (int o = 0; o < 8; o++) add_ops(amx_pkg::CMD_ORIENT, 32'd0, 32'd0, 32'd0, 3'(o));
    add_ops(amx_pkg::CMD_ROTATE, 32'd0, 32'd0, 32'd0, 3'd0);
    add_ops(amx_pkg::CMD_ROTATE, 32'd0, 32'd0, 32'h7fffffff, 3'd0);
    add_ops(amx_pkg::CMD_ROTATE, 32'd0, 32'd0, 32'h80000000, 3'd0);
    add_ops(amx_pkg::CMD_ROTATE, 32'd0, 32'd0, 32'd205887, 3'd0);     // about pi
    add_ops(amx_pkg::CMD_ROTATE, 32'd0, 32'd0, -32'sd102944, 3'd0);   // about -pi/2
    add_known(amx_pkg::CMD_IDENT, 3'd0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_cmd(directed[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n > NUM_RANDOM - 100) quiet = 1'b1;
      k = $urandom_range(0, 99);
      it = make_item(amx_pkg::CMD_MUL, rand_q(), 3'($urandom_range(0, 7)));
      for (int i = 0; i < 9; i++) it.opnd[i] = rand_q();
      if (k < 8) it.cmd = amx_pkg::CMD_IDENT;
      else if (k < 28) it.cmd = amx_pkg::CMD_MUL;
      else if (k < 40) it.cmd = amx_pkg::CMD_SCALE;
      else if (k < 54) it.cmd = amx_pkg::CMD_ROW;
      else if (k < 70) it.cmd = amx_pkg::CMD_ROTATE;
      else if (k < 82) it.cmd = amx_pkg::CMD_XLATE;
      else if (k < 96) it.cmd = amx_pkg::CMD_ORIENT;
      else it.cmd = amx_pkg::CMD_NONE;
      send_cmd(it);
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending_mats.size() != 0 && wait_cnt < STALL_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d commands, checked %0d matrices", n_sent, n_checked);
    $display("Per command: ident %0d mul %0d scale %0d row %0d rot %0d xlate %0d orient %0d none %0d",
             cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3], cmd_hits[4],
             cmd_hits[5], cmd_hits[6], cmd_hits[7]);
    if (errors == 0 && pending_mats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_mats.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
